// ----- design/esr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esr_pkg
// Shared types and constants of the ellipse span rasteriser.
// ----------------------------------------------------------------------------
package esr_pkg;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic KIND_SPAN   = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  localparam logic [1:0] REG_VIEW_LEFT   = 2'd0;
  localparam logic [1:0] REG_VIEW_TOP    = 2'd1;
  localparam logic [1:0] REG_VIEW_WIDTH  = 2'd2;
  localparam logic [1:0] REG_VIEW_HEIGHT = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [14:0] radius_x;
    logic [14:0] radius_y;
    logic [31:0] color;
    logic        fill;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] row;
    logic [11:0] x_start;
    logic [11:0] x_end;
    logic [31:0] span_color;
    logic        done_res;
  } out_item_t;

  typedef struct packed {
    logic [11:0] view_left;
    logic [11:0] view_top;
    logic [12:0] view_width;
    logic [10:0] view_height;
  } view_cfg_t;

endpackage
`default_nettype wire

// ----- design/esr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esr_in_if / esr_out_if
// Valid and ready channels that carry input and result items.
// ----------------------------------------------------------------------------
interface esr_in_if;
  logic              valid;
  logic              ready;
  esr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface esr_out_if;
  logic               valid;
  logic               ready;
  esr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/esr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esr_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module esr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ----- design/esr_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esr_cfg
// Viewport register file behind the APB-style port.
// ----------------------------------------------------------------------------
module esr_cfg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output esr_pkg::view_cfg_t     cfg_o
);
  import esr_pkg::*;

  view_cfg_t cfg_q;
  logic      wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.view_left   <= '0;
      cfg_q.view_top    <= '0;
      cfg_q.view_width  <= 13'd640;
      cfg_q.view_height <= 11'd480;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        REG_VIEW_LEFT:   cfg_q.view_left   <= pwdata[11:0];
        REG_VIEW_TOP:    cfg_q.view_top    <= pwdata[11:0];
        REG_VIEW_WIDTH:  cfg_q.view_width  <= pwdata[12:0];
        REG_VIEW_HEIGHT: cfg_q.view_height <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_VIEW_LEFT:   prdata = {20'd0, cfg_q.view_left};
      REG_VIEW_TOP:    prdata = {20'd0, cfg_q.view_top};
      REG_VIEW_WIDTH:  prdata = {19'd0, cfg_q.view_width};
      REG_VIEW_HEIGHT: prdata = {21'd0, cfg_q.view_height};
      default:         prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

// ----- design/ellipse_span_rasterizer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ellipse_span_rasterizer_top
// Midpoint ellipse rasteriser that turns begin and step items into spans.
// ----------------------------------------------------------------------------
// A begin item loads an ellipse and gives the spans of its centre row; each
// step item advances the midpoint error stepping by one step, which moves the
// row pair out by one row, the span ends in by one column, or both. Every item
// ends with a marker item whose done flag tells whether the ellipse is done.
// Spans are clipped to the viewport set through the APB-style port. The
// per-row filled map is a one-bit RAM of MAX_VIEW_ROWS entries with registered
// read data, updated by read-modify-write, one row at a time. A begin item
// clears the map in a pass of one entry per cycle, then gives its centre row,
// then the setup multiplies (skipped for a flat ellipse) and its marker. A step
// passes through ST_ST1, ST_ST2 and ST_ST3, then ST_ROW, ST_READ and ST_EMIT2
// for each row, with ST_EMIT1 and ST_MUL1 between them for a row in view in
// outline mode, and ends in ST_MARK. A step while no ellipse is active gives
// its done marker straight from the idle state. After reset the map is cleared
// by the same pass before the first item is accepted. Results wait in an output
// register; when the receiver stalls, the block holds in each state with a result.
// ----------------------------------------------------------------------------
module ellipse_span_rasterizer_top #(
  parameter int MAX_VIEW_ROWS = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  esr_in_if.sink     in_if,
  esr_out_if.source  out_if,
  input  wire logic  psel,
  input  wire logic  penable,
  input  wire logic  pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import esr_pkg::*;

  localparam int AW = $clog2(MAX_VIEW_ROWS);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_ROW    = 4'd2;
  localparam logic [3:0] ST_READ   = 4'd3;
  localparam logic [3:0] ST_EMIT1  = 4'd4;
  localparam logic [3:0] ST_EMIT2  = 4'd5;
  localparam logic [3:0] ST_MARK   = 4'd6;
  localparam logic [3:0] ST_ST1    = 4'd7;
  localparam logic [3:0] ST_ST2    = 4'd8;
  localparam logic [3:0] ST_ST3    = 4'd9;
  localparam logic [3:0] ST_MUL1   = 4'd10;
  localparam logic [3:0] ST_MUL2   = 4'd11;

  view_cfg_t cfg;

  esr_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  logic [3:0]  st_q, st_d;
  logic [AW:0] clr_q, clr_d;
  logic signed [16:0] lo_q, up_q, sl_q, sr_q;
  logic signed [16:0] lo_d, up_d, sl_d, sr_d;
  logic signed [47:0] et_q, ec_q, er_q, et_d, ec_d, er_d;
  logic [31:0] a2_q, b2_q, a2_d, b2_d;
  logic [14:0] cl_q, cl_d;
  logic [14:0] a_q, b_q, a_d, b_d;
  logic [31:0] col_q, col_d;
  logic        fill_q, fill_d, act_q, act_d;
  logic        rfill_q, rfill_d;
  logic        which_q, which_d;
  logic        done_q, done_d;
  logic [31:0] prod_q, prod_d;
  out_item_t   ob_q, ob_d;
  logic        ov_q, ov_d;

  logic          ram_we, ram_rd;
  logic [AW-1:0] ram_addr;
  logic          ram_wd;

  esr_ram #(.Width(1), .Depth(MAX_VIEW_ROWS)) u_map (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wd), .rdata_o(ram_rd)
  );

  // Row under consideration and its clipping.
  logic signed [17:0] cur_row, vt, vh, vl, vr, x1, x2;
  logic               row_in, fill_ok, p1_ok, p2_ok;
  logic [AW-1:0]      row_idx;
  logic signed [17:0] row_off;

  always_comb begin
    cur_row = which_q ? 18'(up_q) : 18'(lo_q);
    vt = 18'(cfg.view_top);
    vh = (32'(cfg.view_height) < MAX_VIEW_ROWS) ? 18'(cfg.view_height)
                                                : 18'(MAX_VIEW_ROWS);
    vl = 18'(cfg.view_left);
    vr = vl + 18'(cfg.view_width);
    x1 = 18'(sl_q);
    x2 = 18'(sr_q);
    row_in  = (cur_row >= vt) && (cur_row < vt + vh) && (cfg.view_width != 0);
    row_off = cur_row - vt;
    row_idx = row_off[AW-1:0];
    fill_ok = !(x2 < vl || x1 >= vr);
    p1_ok   = x1 >= vl && x1 < vr;
    p2_ok   = x2 >= vl && x2 < vr;
  end

  logic out_free;
  assign out_free = !ov_q || out_if.ready;
  assign out_if.valid = ov_q;
  assign out_if.data  = ob_q;
  assign in_if.ready  = (st_q == ST_IDLE) && out_free;

  logic signed [47:0] et_step;

  always_comb begin
    st_d = st_q; clr_d = clr_q;
    lo_d = lo_q; up_d = up_q; sl_d = sl_q; sr_d = sr_q;
    et_d = et_q; ec_d = ec_q; er_d = er_q; a2_d = a2_q; b2_d = b2_q;
    cl_d = cl_q; a_d = a_q; b_d = b_q; col_d = col_q; fill_d = fill_q;
    act_d = act_q; rfill_d = rfill_q; which_d = which_q; done_d = done_q;
    prod_d = prod_q;
    ob_d = ob_q; ov_d = ov_q;
    ram_we = 1'b0; ram_addr = row_idx; ram_wd = 1'b1;
    et_step = et_q;
    if (ov_q && out_if.ready) ov_d = 1'b0;
    unique case (st_q)
      ST_CLEAR: begin
        ram_we = 1'b1; ram_wd = 1'b0; ram_addr = clr_q[AW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == (AW+1)'(MAX_VIEW_ROWS - 1)) begin
          st_d = rfill_q ? ST_ROW : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_if.valid && in_if.ready) begin
          if (in_if.data.cmd == CMD_BEGIN) begin
            col_d  = in_if.data.color;
            a_d    = in_if.data.radius_x;
            b_d    = in_if.data.radius_y;
            sl_d   = 17'(signed'(in_if.data.center_x)) - 17'(in_if.data.radius_x);
            sr_d   = 17'(signed'(in_if.data.center_x)) + 17'(in_if.data.radius_x);
            lo_d   = 17'(signed'(in_if.data.center_y));
            up_d   = 17'(signed'(in_if.data.center_y));
            fill_d = in_if.data.fill || (in_if.data.radius_y == '0);
            which_d = 1'b0;
            // rfill_q marks a row pass after the clear; here it flags begin.
            rfill_d = 1'b1;
            clr_d  = '0;
            st_d   = ST_CLEAR;
            if (in_if.data.radius_y == '0) begin
              act_d = 1'b0; cl_d = '0; done_d = 1'b1;
            end else begin
              cl_d = in_if.data.radius_x;
              act_d = in_if.data.radius_x != '0;
              done_d = in_if.data.radius_x == '0;
            end
          end else if (!act_q) begin
            ov_d = 1'b1;
            ob_d = '{kind: KIND_MARKER, row: '0, x_start: '0, x_end: '0,
                     span_color: '0, done_res: 1'b1};
          end else begin
            st_d = ST_ST1;
          end
        end
      end
      ST_ST1: begin
        if (et_q > 0) begin
          lo_d = lo_q + 1'b1;
          up_d = up_q - 1'b1;
          er_d = er_q + 48'(a2_q);
        end
        st_d = ST_ST2;
      end
      ST_ST2: begin
        if (et_q > 0) et_d = et_q - er_q;
        st_d = ST_ST3;
      end
      ST_ST3: begin
        if (et_q <= 0) begin
          cl_d = cl_q - 1'b1;
          sl_d = sl_q + 1'b1;
          sr_d = sr_q - 1'b1;
          et_step = ec_q - 48'(b2_q);
          ec_d = et_step;
          et_d = et_q + et_step;
        end
        which_d = 1'b0;
        rfill_d = 1'b0;
        st_d = ST_ROW;
      end
      ST_ROW: begin
        ram_addr = row_idx;
        st_d = ST_READ;
      end
      ST_READ: begin
        ram_addr = row_idx;
        if (!row_in) begin
          st_d = ST_EMIT2;
        end else if (fill_q) begin
          if (fill_ok && !ram_rd) begin
            if (out_free) begin
              ram_we = 1'b1;
              ov_d = 1'b1;
              ob_d = '{kind: KIND_SPAN, row: cur_row[11:0],
                       x_start: (x1 < vl) ? vl[11:0] : x1[11:0],
                       x_end: (x2 > vr - 1) ? 12'(vr - 1) : x2[11:0],
                       span_color: col_q, done_res: 1'b0};
              st_d = ST_EMIT2;
            end
          end else begin
            st_d = ST_EMIT2;
          end
        end else begin
          st_d = ST_EMIT1;
        end
      end
      ST_EMIT1: begin
        if (!p1_ok) begin
          st_d = ST_MUL1;
        end else if (out_free) begin
          ov_d = 1'b1;
          ob_d = '{kind: KIND_SPAN, row: cur_row[11:0], x_start: x1[11:0],
                   x_end: x1[11:0], span_color: col_q, done_res: 1'b0};
          st_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        if (!p2_ok) begin
          st_d = ST_EMIT2;
        end else if (out_free) begin
          ov_d = 1'b1;
          ob_d = '{kind: KIND_SPAN, row: cur_row[11:0], x_start: x2[11:0],
                   x_end: x2[11:0], span_color: col_q, done_res: 1'b0};
          st_d = ST_EMIT2;
        end
      end
      ST_EMIT2: begin
        // Row finished: a begin or the upper row of a step leads to setup or marker.
        if (rfill_q) begin
          st_d = (b_q == '0) ? ST_MARK : ST_MUL2;
          prod_d = 32'(a_q) * 32'(a_q);
        end else if (!which_q) begin
          which_d = 1'b1;
          st_d = ST_ROW;
        end else begin
          act_d = cl_q != '0;
          done_d = cl_q == '0;
          st_d = ST_MARK;
        end
      end
      ST_MUL2: begin
        // Multiplies are spread over ST_EMIT2 and two passes through this state.
        if (rfill_q) begin
          a2_d = {prod_q[30:0], 1'b0};
          prod_d = 32'(b_q) * 32'(b_q);
          rfill_d = 1'b0;
        end else begin
          b2_d = {prod_q[30:0], 1'b0};
          et_step = 48'(prod_q) * 48'(a_q);
          et_d = et_step;
          ec_d = {et_step[46:0], 1'b0};
          er_d = '0;
          st_d = ST_MARK;
        end
      end
      ST_MARK: begin
        if (out_free) begin
          ov_d = 1'b1;
          ob_d = '{kind: KIND_MARKER, row: '0, x_start: '0, x_end: '0,
                   span_color: '0, done_res: done_q};
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR; clr_q <= '0; ov_q <= 1'b0; act_q <= 1'b0;
      rfill_q <= 1'b0; which_q <= 1'b0; done_q <= 1'b0;
      lo_q <= '0; up_q <= '0; sl_q <= '0; sr_q <= '0;
      et_q <= '0; ec_q <= '0; er_q <= '0; a2_q <= '0; b2_q <= '0;
      cl_q <= '0; col_q <= '0; fill_q <= 1'b0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; ov_q <= ov_d; act_q <= act_d;
      rfill_q <= rfill_d; which_q <= which_d; done_q <= done_d;
      lo_q <= lo_d; up_q <= up_d; sl_q <= sl_d; sr_q <= sr_d;
      et_q <= et_d; ec_q <= ec_d; er_q <= er_d; a2_q <= a2_d; b2_q <= b2_d;
      cl_q <= cl_d; col_q <= col_d; fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d; a_q <= a_d; b_q <= b_d; prod_q <= prod_d;
  end
endmodule
`default_nettype wire

// ----- design/esr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esr_checker
// Port-level checks of the ellipse span rasteriser, bound to the top level.
// ----------------------------------------------------------------------------
module esr_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire esr_pkg::out_item_t out_data
);
  import esr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_marker_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.kind == KIND_MARKER |->
      out_data.row == '0 && out_data.span_color == '0)
    else $error("marker carries span fields");

  a_span_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.kind == KIND_SPAN |-> !out_data.done_res)
    else $error("span item flagged done");

  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("input item accepted while a result item is stalled");
endmodule

bind ellipse_span_rasterizer_top esr_checker u_esr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
`default_nettype wire
